### design/group_reverse_stream_top_assert.svh
// ---------------------------------------------------------------------------
// group_reverse_stream_top_assert.svh
// Assertion macros for the group reverse stream block.
// ---------------------------------------------------------------------------
`ifndef GROUP_REVERSE_STREAM_TOP_ASSERT_SVH
`define GROUP_REVERSE_STREAM_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked on every clock edge out of reset
`define GRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GRS_ASSERT_NOW(lbl, ante, cons, msg)
`define GRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/grs_pkg.sv
// ---------------------------------------------------------------------------
// grs_pkg
// Shared types and constants of the group reverse stream block.
// ---------------------------------------------------------------------------
package grs_pkg;

  localparam int GROUP_SIZE_W   = 5;
  localparam int GROUP_SIZE_RST = 2;

  // strobes from the sequencer to the group buffer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } grs_mem_ctl_t;

endpackage

### design/grs_buffer.sv
// ---------------------------------------------------------------------------
// grs_buffer
// Group buffer: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module grs_buffer #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = 4
) (
  input  logic                   clk,
  input  grs_pkg::grs_mem_ctl_t  ctl,
  input  logic [ADDR_BITS-1:0]   wr_addr,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic [ADDR_BITS-1:0]   rd_addr,
  output logic [WIDTH-1:0]       rd_data
);
  import grs_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first: hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/group_reverse_stream_top.sv
// ---------------------------------------------------------------------------
// group_reverse_stream_top
// Buffer list words in groups of the configured size and emit each full
// group in reverse order; a short final group leaves in its original order.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_data_in, in_end_of_list
//   out      output     out_valid/out_stall out_data_out, out_run_last,
//                                           out_list_done
//   cfg      input      cfg_wr_en           cfg_wr_data (group size)
//
// An input word is taken and written to the group buffer. A word that
// closes a run sends the sequencer through S_READ to set up the first
// read, then the run of n words leaves at one word per cycle while
// out_stall is low; the buffer has a single write and read port pair.
// While a run drains, in_stall is high; out_stall holds the drain in place.
// Reset clears the fill count and the sequencer and sets group size to 2;
// the buffer itself is not cleared, as only entries of the current group
// are ever read.
// ---------------------------------------------------------------------------
module group_reverse_stream_top #(
  parameter int MAX_GROUP = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [DATA_BITS-1:0] in_data_in,
  input  logic                        in_end_of_list,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_BITS-1:0] out_data_out,
  output logic                        out_run_last,
  output logic                        out_list_done,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [4:0]                  cfg_wr_data
);
  import grs_pkg::*;

  // count holds 0..MAX_GROUP, address 0..MAX_GROUP-1
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int AW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;  // take input words
  localparam logic [1:0] S_READ = 2'd1;  // issue first read of a run
  localparam logic [1:0] S_LOAD = 2'd2;  // move words to the output register

  logic [1:0]              state_r, state_nxt;
  logic [GROUP_SIZE_W-1:0] group_size_r;
  logic [CNT_W-1:0]        fill_cnt_r, fill_cnt_nxt;
  logic [CNT_W-1:0]        run_len_r, run_len_nxt;
  logic [CNT_W-1:0]        emit_idx_r, emit_idx_nxt;
  logic                    reverse_r, reverse_nxt;
  logic                    eol_r, eol_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  logic signed [DATA_BITS-1:0] out_data_r;
  logic                    out_run_last_r;
  logic                    out_list_done_r;

  logic [CNT_W-1:0]        k_eff;
  logic [CNT_W-1:0]        wr_base;
  logic [CNT_W-1:0]        cnt_new;
  logic                    grp_full;
  logic                    in_acc;
  logic                    out_free;
  logic                    is_last;
  logic [CNT_W-1:0]        rd_idx;
  logic [CNT_W-1:0]        rd_src;
  grs_mem_ctl_t            mem_ctl;
  logic [DATA_BITS-1:0]    rd_data;

  // -------------------------------------------------------------------------
  // Configuration: zero acts as one, sizes above MAX_GROUP saturate
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_W'(GROUP_SIZE_RST);
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (group_size_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(group_size_r) > MAX_GROUP) begin
      k_eff = CNT_W'(MAX_GROUP);
    end else begin
      k_eff = CNT_W'(group_size_r);
    end
  end

  // -------------------------------------------------------------------------
  // Input side: write the word at the fill position, decide whether it
  // closes a run (group full, or end of list on a short group)
  // -------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_base  = (fill_cnt_r >= CNT_W'(MAX_GROUP)) ? CNT_W'(MAX_GROUP - 1) : fill_cnt_r;
  assign cnt_new  = wr_base + CNT_W'(1);
  assign grp_full = (cnt_new >= k_eff);

  // -------------------------------------------------------------------------
  // Output side: the output register frees when empty or being taken
  // -------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (emit_idx_r == run_len_r - CNT_W'(1));
  assign out_load = (state_r == S_LOAD) && out_free;

  // read the current index when opening a run, the following one while
  // draining so that each output word finds its data ready
  assign rd_idx = (state_r == S_READ) ? emit_idx_r : emit_idx_r + CNT_W'(1);
  assign rd_src = reverse_r ? (run_len_r - CNT_W'(1) - rd_idx) : rd_idx;

  always_comb begin
    mem_ctl.wr_en = in_acc;
    mem_ctl.rd_en = (state_r == S_READ) || (out_load && !is_last);
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    run_len_nxt   = run_len_r;
    emit_idx_nxt  = emit_idx_r;
    reverse_nxt   = reverse_r;
    eol_nxt       = eol_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (grp_full || in_end_of_list) begin
            run_len_nxt  = cnt_new;
            reverse_nxt  = grp_full;
            eol_nxt      = in_end_of_list;
            emit_idx_nxt = '0;
            fill_cnt_nxt = '0;
            state_nxt    = S_READ;
          end else begin
            fill_cnt_nxt = cnt_new;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_cnt_r  <= '0;
      run_len_r   <= '0;
      emit_idx_r  <= '0;
      reverse_r   <= 1'b0;
      eol_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      run_len_r   <= run_len_nxt;
      emit_idx_r  <= emit_idx_nxt;
      reverse_r   <= reverse_nxt;
      eol_r       <= eol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload: load from buffer read data, hold while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r      <= rd_data;
      out_run_last_r  <= is_last;
      out_list_done_r <= is_last && eol_r;
    end
  end

  grs_buffer #(
    .DEPTH     (MAX_GROUP),
    .WIDTH     (DATA_BITS),
    .ADDR_BITS (AW)
  ) u_buffer (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_base[AW-1:0]),
    .wr_data (in_data_in),
    .rd_addr (rd_src[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_run_last  = out_run_last_r;
  assign out_list_done = out_list_done_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
`include "group_reverse_stream_top_assert.svh"

  `GRS_ASSERT_NOW(a_fill_below_max, 1'b1, fill_cnt_r < CNT_W'(MAX_GROUP), "fill count reached group buffer depth")
  `GRS_ASSERT_NOW(a_idx_in_run, state_r == S_LOAD, emit_idx_r < run_len_r, "drain index past run length")
  `GRS_ASSERT_NOW(a_done_is_last, out_valid_r && out_list_done_r, out_run_last_r, "list end flagged off a run end")
  `GRS_ASSERT_NEXT(a_read_then_load, state_r == S_READ, state_r == S_LOAD, "run setup did not move to drain")

endmodule
